[design/gse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_pkg
// Shared types and constants of the gray Sobel edge stream.
// ----------------------------------------------------------------------------
package gse_pkg;

   localparam int GSE_MAX_WIDTH = 2048;

   localparam int CFG_W     = 12;
   localparam int ROW_W     = 12;
   localparam int OCOL_W    = 11;
   localparam int PIX_W     = 8;
   localparam int MIN_DIM   = 3;
   localparam int EDGE_MAX  = 255;

   // floor(x / 3) == (x * 683) >> 11 for x <= 765
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // position flags of the pixel in the compute stage
   typedef struct packed {
      logic              row_ge1;
      logic              col_ge1;
      logic              interior;
      logic              last_col;
      logic              last_row;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  row_m1;
      logic [OCOL_W-1:0] col;
      logic [OCOL_W-1:0] col_m1;
   } gse_pos_type;

   // up to three results caused by one pixel, slot 0 first
   typedef struct packed {
      logic [2:0]        slot_valid;
      logic [PIX_W-1:0]  edge_value;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  row_m1;
      logic [OCOL_W-1:0] col;
      logic [OCOL_W-1:0] col_m1;
      logic              frame_done;
   } gse_rset_type;

endpackage

[design/gse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gse_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_kernel
// 3x3 window registers, Sobel gradients, L1 magnitude and result set build.
// ----------------------------------------------------------------------------
module gse_kernel (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [gse_pkg::PIX_W-1:0]  top_pix,
   input  logic [gse_pkg::PIX_W-1:0]  mid_pix,
   input  logic [gse_pkg::PIX_W-1:0]  bot_pix,
   input  gse_pkg::gse_pos_type       pos,
   output gse_pkg::gse_rset_type      rset
);
   import gse_pkg::*;

   // 0..2: left column top to bottom, 3..5: center column
   logic [PIX_W-1:0] win_ff [6];

   logic [10:0] left_sum, right_sum, upper_sum, lower_sum;
   logic signed [11:0] gx, gy;
   logic [10:0] abs_gx, abs_gy;
   logic [11:0] mag;
   logic [PIX_W-1:0] sat_mag;

   always_comb begin
      left_sum  = 11'(win_ff[0]) + {2'b0, win_ff[1], 1'b0} + 11'(win_ff[2]);
      right_sum = 11'(top_pix) + {2'b0, mid_pix, 1'b0} + 11'(bot_pix);
      upper_sum = 11'(win_ff[0]) + {2'b0, win_ff[3], 1'b0} + 11'(top_pix);
      lower_sum = 11'(win_ff[2]) + {2'b0, win_ff[5], 1'b0} + 11'(bot_pix);
      gx = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
      gy = $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
      abs_gx = gx[11] ? 11'(-gx) : 11'(gx);
      abs_gy = gy[11] ? 11'(-gy) : 11'(gy);
      mag = 12'(abs_gx) + 12'(abs_gy);
      sat_mag = (mag > 12'(EDGE_MAX)) ? PIX_W'(EDGE_MAX) : mag[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= bot_pix;
      end
   end

   always_comb begin
      rset.slot_valid[0] = pos.row_ge1 & pos.col_ge1;
      rset.slot_valid[1] = pos.row_ge1 & pos.last_col;
      rset.slot_valid[2] = pos.last_row;
      rset.edge_value    = pos.interior ? sat_mag : '0;
      rset.row           = pos.row;
      rset.row_m1        = pos.row_m1;
      rset.col           = pos.col;
      rset.col_m1        = pos.col_m1;
      rset.frame_done    = pos.last_col;
   end

endmodule

[design/gse_rsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_rsp_queue
// Holds the result set of one pixel and drains it one transaction a cycle while ready.
// ----------------------------------------------------------------------------
module gse_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  gse_pkg::gse_rset_type rset_in,
   output logic                  can_load,
   output logic [31:0]           rsp_tdata,   // edge_value[7:0], out_row[19:8], out_col[30:20]
   output logic                  rsp_tlast,   // frame_done
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);
   import gse_pkg::*;

   logic [2:0]   slots_ff, slots_in, slots_left;
   gse_rset_type hold_ff;
   logic [2:0]   head;
   logic         take;
   logic [PIX_W-1:0]  o_edge;
   logic [ROW_W-1:0]  o_row;
   logic [OCOL_W-1:0] o_col;
   logic              o_done;

   assign head       = slots_ff & (~slots_ff + 3'd1);
   assign take       = rsp_tvalid & rsp_tready;
   assign slots_left = take ? (slots_ff & ~head) : slots_ff;
   assign can_load   = (slots_left == 3'd0);
   assign slots_in   = load ? rset_in.slot_valid : slots_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
      end else begin
         slots_ff <= slots_in;
      end
      if (load) begin
         hold_ff <= rset_in;
      end
   end

   always_comb begin
      priority case (1'b1)
         slots_ff[0]: begin
            o_edge = hold_ff.edge_value;
            o_row  = hold_ff.row_m1;
            o_col  = hold_ff.col_m1;
            o_done = 1'b0;
         end
         slots_ff[1]: begin
            o_edge = '0;
            o_row  = hold_ff.row_m1;
            o_col  = hold_ff.col;
            o_done = 1'b0;
         end
         default: begin
            o_edge = '0;
            o_row  = hold_ff.row;
            o_col  = hold_ff.col;
            o_done = hold_ff.frame_done;
         end
      endcase
   end

   assign rsp_tvalid = |slots_ff;
   assign rsp_tdata  = {1'b0, o_col, o_row, o_edge};
   assign rsp_tlast  = o_done;

endmodule

[design/gray_sobel_edge_stream.sv]
`timescale 1ns / 1ps
// An accepted pixel is registered, then loaded into the result queue that drives the output.
// Throughput: one pixel per cycle while each pixel yields at most one result and the
//   result port is ready; a pixel that yields two or three (last column, last row)
//   holds the input while the result port moves them one transaction per cycle.
// Reset: synchronous, active high; clears positions, pipeline and output, loads
//   640x480. Line store RAM is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// gray_sobel_edge_stream
// RGB to gray, two line stores in one RAM, 3x3 Sobel L1 edge magnitude.
// ----------------------------------------------------------------------------
module gray_sobel_edge_stream #(
   parameter int MAX_WIDTH = gse_pkg::GSE_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [gse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gse_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [23:0]                     req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   output logic [31:0]                     rsp_tdata,   // edge_value[7:0], out_row[19:8], out_col[30:20]
   output logic                            rsp_tlast,   // frame_done
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import gse_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;

   logic             a_valid_ff;
   logic [PIX_W-1:0] a_gray_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic [COL_W-1:0] a_col_ff;

   logic [EW-1:0]    width_ext, eff_w;
   logic [ROW_W-1:0] eff_h;
   logic             accept, advance, can_load;
   logic             in_last_col, in_last_row;
   logic [9:0]       sum3;
   logic [19:0]      gray_prod;
   logic [2*PIX_W-1:0] line_rd;
   gse_pos_type      pos;
   gse_rset_type     rset;

   always_comb begin
      width_ext = EW'(width_ff);
      eff_w = width_ext;
      if (width_ext < EW'(MIN_DIM)) begin
         eff_w = EW'(MIN_DIM);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end
      eff_h = (height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_ff;
   end

   assign advance    = a_valid_ff & can_load;
   assign req_tready = ~a_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   assign in_last_col = (EW'(col_ff) == eff_w - EW'(1));
   assign in_last_row = (row_ff == eff_h - ROW_W'(1));

   always_comb begin
      sum3 = 10'(req_tdata[7:0]) + 10'(req_tdata[15:8]) + 10'(req_tdata[23:16]);
      gray_prod = 20'(sum3) * 20'(GRAY_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_W'(640);
         height_ff  <= CFG_W'(480);
         row_ff     <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            endcase
            row_ff <= '0;
            col_ff <= '0;
         end else if (accept) begin
            if (in_last_col) begin
               col_ff <= '0;
               row_ff <= in_last_row ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         a_gray_ff <= gray_prod[GRAY_SHIFT +: PIX_W];
         a_row_ff  <= row_ff;
         a_col_ff  <= col_ff;
      end
   end

   always_comb begin
      pos.row_ge1  = (a_row_ff != '0);
      pos.col_ge1  = (a_col_ff != '0);
      pos.interior = (a_row_ff >= ROW_W'(2)) && (a_col_ff >= COL_W'(2));
      pos.last_col = (EW'(a_col_ff) == eff_w - EW'(1));
      pos.last_row = (a_row_ff == eff_h - ROW_W'(1));
      pos.row      = a_row_ff;
      pos.row_m1   = a_row_ff - ROW_W'(1);
      pos.col      = OCOL_W'(a_col_ff);
      pos.col_m1   = OCOL_W'(a_col_ff - COL_W'(1));
   end

   // upper byte: two rows back, lower byte: previous row
   gse_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (a_col_ff),
      .wr_data ({line_rd[PIX_W-1:0], a_gray_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   gse_kernel u_kernel (
      .clock   (clock),
      .advance (advance),
      .top_pix (line_rd[2*PIX_W-1:PIX_W]),
      .mid_pix (line_rd[PIX_W-1:0]),
      .bot_pix (a_gray_ff),
      .pos     (pos),
      .rset    (rset)
   );

   gse_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .rset_in    (rset),
      .can_load   (can_load),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

[design/gse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_checker
// Port-level assertions for gray_sobel_edge_stream, attached by bind.
// ----------------------------------------------------------------------------
module gse_checker (
   input logic        clock,
   input logic        reset,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'd0 && rsp_tdata[19:8] != 12'd0)
      else $error("frame end result not a zero on the last row");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] != 8'd0 |-> rsp_tdata[19:8] != 12'd0
         && rsp_tdata[30:20] != 11'd0 && !rsp_tlast)
      else $error("nonzero edge value on the frame border");

endmodule

bind gray_sobel_edge_stream gse_checker u_gse_checker (.*);

[test/gse_edge_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_edge_checker
// Watches the pixel, result and register ports of the gray Sobel edge stream,
// predicts every edge result from the accepted pixels and compares each
// accepted result field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module gse_edge_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [gse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gse_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [23:0]                   req_tdata,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [31:0]                   rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output int                            error_count,
   output int                            edges_outstanding
);
   import gse_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]  edge_value;
      logic [ROW_W-1:0]  row;
      logic [OCOL_W-1:0] col;
      logic              frame_done;
   } edge_result_type;

   logic [PIX_W-1:0] older_row [GSE_MAX_WIDTH];
   logic [PIX_W-1:0] newer_row [GSE_MAX_WIDTH];
   logic [PIX_W-1:0] win [6];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int               cur_row;
   int               cur_col;
   edge_result_type  edge_q [$];

   task automatic push_edge(input int val, input int row, input int col, input bit done);
      edge_result_type e;
      e.edge_value = PIX_W'(val);
      e.row        = ROW_W'(row);
      e.col        = OCOL_W'(col);
      e.frame_done = done;
      edge_q.push_back(e);
   endtask

   task automatic sobel_predict(input logic [23:0] rgb);
      int w, h, r, c, ci;
      int top, mid, bot, gx, gy, mag;
      int lt, lm, lb, ct, cb;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > GSE_MAX_WIDTH) w = GSE_MAX_WIDTH;
      if (h < MIN_DIM) h = MIN_DIM;
      r = cur_row;
      c = cur_col;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      ci = c % GSE_MAX_WIDTH;
      top = int'(older_row[ci]);
      mid = int'(newer_row[ci]);
      bot = (int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3;

      if (r >= 1 && c >= 1) begin
         mag = 0;
         if (r - 1 >= 1 && c - 1 >= 1 && c - 1 <= w - 2) begin
            lt = int'(win[0]);
            lm = int'(win[1]);
            lb = int'(win[2]);
            ct = int'(win[3]);
            cb = int'(win[5]);
            gx = (lt + 2 * lm + lb) - (top + 2 * mid + bot);
            gy = (lt + 2 * ct + top) - (lb + 2 * cb + bot);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > EDGE_MAX) mag = EDGE_MAX;
         end
         push_edge(mag, r - 1, c - 1, 1'b0);
      end
      if (r >= 1 && c == w - 1) push_edge(0, r - 1, w - 1, 1'b0);
      if (r == h - 1) push_edge(0, r, c, c == w - 1);

      older_row[ci] = PIX_W'(mid);
      newer_row[ci] = PIX_W'(bot);
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(top);
      win[4] = PIX_W'(mid);
      win[5] = PIX_W'(bot);

      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
         cur_row = r;
      end
   endtask

   task automatic check_edge();
      edge_result_type got;
      edge_result_type exp;
      got.edge_value = rsp_tdata[7:0];
      got.row        = rsp_tdata[19:8];
      got.col        = rsp_tdata[30:20];
      got.frame_done = rsp_tlast;
      if (edge_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: unexpected edge result val=%0d row=%0d col=%0d done=%0b",
                     $time, got.edge_value, got.row, got.col, got.frame_done);
      end else begin
         exp = edge_q.pop_front();
         if (got !== exp) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: edge result error, expected val=%0d row=%0d col=%0d done=%0b",
                        $time, exp.edge_value, exp.row, exp.col, exp.frame_done);
               $display("%0t: edge result error, got      val=%0d row=%0d col=%0d done=%0b",
                        $time, got.edge_value, got.row, got.col, got.frame_done);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GSE_MAX_WIDTH; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
         end
         for (int i = 0; i < 6; i++) win[i] = '0;
         width_reg  = CFG_W'(640);
         height_reg = CFG_W'(480);
         cur_row = 0;
         cur_col = 0;
         edge_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
            cur_row = 0;
            cur_col = 0;
         end
         if (req_tvalid && req_tready) sobel_predict(req_tdata);
         if (rsp_tvalid && rsp_tready) check_edge();
      end
      edges_outstanding = edge_q.size();
   end

endmodule

[test/tb_gray_sobel_edge_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_sobel_edge_stream
// Drives RGB frames of many sizes into the gray Sobel edge stream with random
// source gaps and sink stalls; the edge checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_gray_sobel_edge_stream;
   import gse_pkg::*;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 220;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic [23:0]          req_tdata;    // blue[7:0], green[15:8], red[23:16]
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          rsp_tdata;    // edge_value[7:0], out_row[19:8], out_col[30:20]
   logic                 rsp_tlast;    // frame_done
   logic                 rsp_tvalid;
   logic                 rsp_tready;

   int error_count;
   int edges_outstanding;
   int cycle_count;
   bit calm;
   int stall_left;
   int run_left;
   int cur_w;
   int cur_h;

   gray_sobel_edge_stream i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   gse_edge_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_tdata         (req_tdata),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .error_count       (error_count),
      .edges_outstanding (edges_outstanding)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // sink backpressure: random stall bursts between ready stretches
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else begin
         if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
            else run_left = $urandom_range(1, 30);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            run_left--;
         end
      end
   end

   function automatic int eff_width(input int w);
      return (w < MIN_DIM) ? MIN_DIM : ((w > GSE_MAX_WIDTH) ? GSE_MAX_WIDTH : w);
   endfunction

   function automatic logic [23:0] rand_rgb();
      case ($urandom_range(0, 3))
         0: return {3{($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00}};
         1: return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                    ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                    ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic send_pixel(input logic [23:0] rgb);
      int gap;
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= rgb;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(rand_rgb());
   endtask

   // drain: no pixel in flight and no result outstanding
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (edges_outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(val);
   endtask

   task automatic configure(input int w, input int h, input bit set_w, input bit set_h);
      wait_idle();
      if (set_w) begin
         write_csr(CSR_FRAME_WIDTH, w);
         cur_w = w;
      end
      if (set_h) begin
         write_csr(CSR_FRAME_HEIGHT, h);
         cur_h = h;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [23:0] bars  [9];
      logic [23:0] chans [9];
      logic [23:0] ramp  [9];
      int random_items;
      int w_eff, h_eff, frame_px, count, which;

      calm        = 1'b0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_FRAME_WIDTH;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      cur_w       = 640;
      cur_h       = 480;
      bars  = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'h000000};
      chans = '{24'h0000FF, 24'h00FF00, 24'hFF0000,
                24'h010100, 24'h020201, 24'hFFFFFE,
                24'h000000, 24'hFFFFFF, 24'h808080};
      ramp  = '{24'h000000, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry 640x480: start of the first row gives nothing
      send_random(16);

      configure(3, 3, 1'b1, 1'b1);
      foreach (bars[i]) send_pixel(bars[i]);
      // sizes below the minimum act as 3
      configure(1, 0, 1'b1, 1'b1);
      foreach (chans[i]) send_pixel(chans[i]);
      configure(2, 2, 1'b1, 1'b1);
      foreach (ramp[i]) send_pixel(ramp[i]);

      // widest frame, width clamped to the line store depth
      configure(4095, 3, 1'b1, 1'b1);
      send_random(16);
      // tallest frame, first rows
      configure(3, 4095, 1'b1, 1'b1);
      send_random(3 * 8);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         which = $urandom_range(0, 5);
         configure(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9),
                   ($urandom_range(0, 9) == 0) ?
                      (($urandom_range(0, 1) != 0) ? 4095 : $urandom_range(0, 2)) :
                      $urandom_range(3, 6),
                   which != 1, which != 0);
         w_eff = eff_width(cur_w);
         h_eff = (cur_h < MIN_DIM) ? MIN_DIM : cur_h;
         frame_px = w_eff * h_eff;
         if (h_eff > 16) count = $urandom_range(1, 3 * w_eff);
         else begin
            case ($urandom_range(0, 4))
               0: count = $urandom_range(1, frame_px - 1);
               1: count = 2 * frame_px;
               default: count = frame_px;
            endcase
         end
         send_random(count);
         random_items += count;
      end

      calm = 1'b1;
      configure(5, 4, 1'b1, 1'b1);
      send_random(40);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (edges_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
